@@ hdl/running_triframe_median_background_unit_assert.svh @@
`ifndef RUNNING_TRIFRAME_MEDIAN_BACKGROUND_UNIT_ASSERT_SVH
`define RUNNING_TRIFRAME_MEDIAN_BACKGROUND_UNIT_ASSERT_SVH

// Implication check on clk, off while arst_n is low
`define RTMB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a signal keeps its value on the next edge when the condition holds
`define RTMB_ASSERT_HOLD(label, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> $stable(sig)) \
		else $error(msg);

`endif

@@ hdl/rtmb_pkg.sv @@
`timescale 1ns / 1ps

package rtmb_pkg;

	localparam int MAX_FRAME_BYTES = 1048576;
	localparam int ADDR_W          = 20;
	localparam int LEN_W           = 21;
	localparam int SAMPLE_W        = 8;
	localparam int IN_TDATA_W      = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int QPTR_W          = 2;
	localparam int QCNT_W          = 3;
	localparam logic [LEN_W-1:0] FRAME_LEN_RESET = LEN_W'(921600);

	// Command carried on the input tuser bit
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Role of the frame currently arriving
	typedef enum logic [1:0] {
		SLOT_FIRST = 2'd0,
		SLOT_HOLD  = 2'd1,
		SLOT_MERGE = 2'd2
	} slot_t;

	// Work kind of one queued item
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_FIRST = 2'd1,
		OP_HOLD  = 2'd2,
		OP_MERGE = 2'd3
	} op_kind_t;

	typedef struct packed {
		op_kind_t              kind;
		logic [ADDR_W-1:0]     addr;
		logic [SAMPLE_W-1:0]   sample;
		logic                  bg_ready;
		logic                  frame_end;
	} op_t;

	function automatic logic [SAMPLE_W-1:0] med3(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c
	);
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		lo = (b < c) ? b : c;
		hi = (b < c) ? c : b;
		if (a < lo)
			return lo;
		if (a > hi)
			return hi;
		return a;
	endfunction

endpackage

@@ hdl/running_triframe_median_background_unit.sv @@
`timescale 1ns / 1ps
// Running median-of-three background estimator. Push beats (tuser = 0) carry frame bytes in
// raster order; the first frame of frame_length bytes fills the background, then frames
// alternate between being held and being merged, where each background byte becomes the
// median of old background, held byte and new byte. Read beats (tuser = 1) return the
// background byte at byte_index. Every input beat yields exactly one output beat: tdata is
// the background byte after the update (or the byte read), tuser is high once the first
// frame is stored, tlast marks the push that ended a frame. The unit takes one beat per
// clock while the output is not stalled; a result passes through a queue slot and the
// registered read of the two on-chip byte stores, after which the output register holds it.
// A four-entry queue sits between the input classifier and the store pipeline, so input
// tready drops only when that queue is full. Write frame_length only while no beats are in
// flight.
module running_triframe_median_background_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [7:0] sample, [27:8] byte_index, [31:28] zero
	input  logic [rtmb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// [0] command
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] value
	output logic [rtmb_pkg::SAMPLE_W-1:0]     m_axis_tdata,
	// [0] background_ready
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtmb_pkg::LEN_W-1:0]        cfg_data
);
	import rtmb_pkg::*;

	logic q_full;
	logic op_valid;
	op_t  op;
	logic head_valid;
	op_t  head;
	logic pop;

	assign s_axis_tready = !q_full;

	// Classify incoming beats
	rtmb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.op_valid      (op_valid),
		.op            (op)
	);

	// Decouple front and back
	rtmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (op_valid),
		.wr_op      (op),
		.full       (q_full),
		.rd_en      (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Store access, median and output register
	rtmb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ hdl/rtmb_front.sv @@
`timescale 1ns / 1ps

module rtmb_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [rtmb_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	input  logic                              s_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtmb_pkg::LEN_W-1:0]        cfg_data,
	output logic                              op_valid,
	output rtmb_pkg::op_t                     op
);
	import rtmb_pkg::*;

	logic [LEN_W-1:0]  frame_length_q;
	logic [ADDR_W-1:0] pos_q;
	slot_t             slot_q;
	slot_t             slot_next;
	logic              first_done_q;
	logic [LEN_W-1:0]  len_eff;
	logic [LEN_W-1:0]  pos_inc;
	logic              wrap;
	logic              accept;
	logic              push;
	op_kind_t          push_kind;

	assign cfg_ready = 1'b1;
	assign accept    = s_axis_tvalid & s_axis_tready;
	assign push      = accept & (cmd_t'(s_axis_tuser) == CMD_PUSH);

	// Clamp the frame length into 1..MAX_FRAME_BYTES
	always_comb begin
		if (frame_length_q == '0)
			len_eff = LEN_W'(1);
		else if (frame_length_q > LEN_W'(MAX_FRAME_BYTES))
			len_eff = LEN_W'(MAX_FRAME_BYTES);
		else
			len_eff = frame_length_q;
	end

	assign pos_inc = {1'b0, pos_q} + LEN_W'(1);
	assign wrap    = (pos_inc >= len_eff);

	// Next frame role on a frame boundary
	always_comb begin
		slot_next = slot_q;
		unique case (slot_q)
			SLOT_FIRST: if (wrap) slot_next = SLOT_HOLD;
			SLOT_HOLD:  if (wrap) slot_next = SLOT_MERGE;
			SLOT_MERGE: if (wrap) slot_next = SLOT_HOLD;
			default:    slot_next = SLOT_FIRST;
		endcase
	end

	// Map frame role to the work kind
	always_comb begin
		unique case (slot_q)
			SLOT_FIRST: push_kind = OP_FIRST;
			SLOT_HOLD:  push_kind = OP_HOLD;
			SLOT_MERGE: push_kind = OP_MERGE;
			default:    push_kind = OP_FIRST;
		endcase
	end

	// Frame length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_length_q <= FRAME_LEN_RESET;
		else if (cfg_valid && cfg_ready)
			frame_length_q <= cfg_data;
	end

	// Advance position and frame role on each pushed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			slot_q       <= SLOT_FIRST;
			first_done_q <= 1'b0;
		end else if (push) begin
			pos_q  <= wrap ? '0 : pos_inc[ADDR_W-1:0];
			slot_q <= slot_next;
			if (wrap && slot_q == SLOT_FIRST)
				first_done_q <= 1'b1;
		end
	end

	// Classify the beat for the back end
	always_comb begin
		op_valid = accept;
		if (cmd_t'(s_axis_tuser) == CMD_READ) begin
			op.kind      = OP_READ;
			op.addr      = s_axis_tdata[SAMPLE_W +: ADDR_W];
			op.bg_ready  = first_done_q;
			op.frame_end = 1'b0;
		end else begin
			op.kind      = push_kind;
			op.addr      = pos_q;
			op.bg_ready  = first_done_q | (wrap & (slot_q == SLOT_FIRST));
			op.frame_end = wrap;
		end
		op.sample = s_axis_tdata[SAMPLE_W-1:0];
	end

endmodule

@@ hdl/rtmb_queue.sv @@
`timescale 1ns / 1ps

module rtmb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  rtmb_pkg::op_t wr_op,
	output logic          full,
	input  logic          rd_en,
	output logic          head_valid,
	output rtmb_pkg::op_t head
);
	import rtmb_pkg::*;

	op_t               entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (wr_en)
			entry_q[wr_ptr_q] <= wr_op;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (wr_en && !rd_en)
				count_q <= count_q + QCNT_W'(1);
			else if (rd_en && !wr_en)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

@@ hdl/rtmb_back.sv @@
`timescale 1ns / 1ps

module rtmb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  rtmb_pkg::op_t                 head,
	output logic                          pop,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rtmb_pkg::SAMPLE_W-1:0] m_axis_tdata,
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);
	import rtmb_pkg::*;

	logic [SAMPLE_W-1:0] bg_mem   [MAX_FRAME_BYTES];
	logic [SAMPLE_W-1:0] held_mem [MAX_FRAME_BYTES];

	logic                en;
	logic                s1_valid;
	op_t                 op_s1;
	logic [SAMPLE_W-1:0] bg_rd_q;
	logic [SAMPLE_W-1:0] held_rd_q;
	logic                fwd_bg_v_q;
	logic                fwd_held_v_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	logic [SAMPLE_W-1:0] fwd_data_q;
	logic [SAMPLE_W-1:0] bg_cur;
	logic [SAMPLE_W-1:0] held_cur;
	logic [SAMPLE_W-1:0] result;
	logic                wr_bg;
	logic                wr_held;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] out_value_q;
	logic                out_ready_q;
	logic                out_end_q;

	assign en  = !out_valid_q || m_axis_tready;
	assign pop = en && head_valid;

	// Read both stores for the item leaving the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			bg_rd_q   <= bg_mem[head.addr];
			held_rd_q <= held_mem[head.addr];
		end
	end

	// Take the last write when it hit the same address as this read
	assign bg_cur   = (fwd_bg_v_q && fwd_addr_q == op_s1.addr) ? fwd_data_q : bg_rd_q;
	assign held_cur = (fwd_held_v_q && fwd_addr_q == op_s1.addr) ? fwd_data_q : held_rd_q;

	// Work out the result and which store gets written
	always_comb begin
		result  = bg_cur;
		wr_bg   = 1'b0;
		wr_held = 1'b0;
		unique case (op_s1.kind)
			OP_READ: begin
				result = bg_cur;
			end
			OP_FIRST: begin
				result = op_s1.sample;
				wr_bg  = s1_valid;
			end
			OP_HOLD: begin
				result  = bg_cur;
				wr_held = s1_valid;
			end
			OP_MERGE: begin
				result = med3(bg_cur, held_cur, op_s1.sample);
				wr_bg  = s1_valid;
			end
			default: begin
				result = bg_cur;
			end
		endcase
	end

	// Write the background store
	always_ff @(posedge clk) begin
		if (en && wr_bg)
			bg_mem[op_s1.addr] <= result;
	end

	// Write the held frame store
	always_ff @(posedge clk) begin
		if (en && wr_held)
			held_mem[op_s1.addr] <= op_s1.sample;
	end

	// Remember the write made on this edge for the item right behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_bg_v_q   <= 1'b0;
			fwd_held_v_q <= 1'b0;
		end else if (en) begin
			fwd_bg_v_q   <= wr_bg;
			fwd_held_v_q <= wr_held;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_addr_q <= op_s1.addr;
			fwd_data_q <= wr_held ? op_s1.sample : result;
		end
	end

	// Stage one: item with its store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid <= 1'b0;
		else if (en)
			s1_valid <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop)
			op_s1 <= head;
	end

	// Output register; hold while the beat is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (en && s1_valid) begin
			out_value_q <= result;
			out_ready_q <= op_s1.bg_ready;
			out_end_q   <= op_s1.frame_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_value_q;
	assign m_axis_tuser  = out_ready_q;
	assign m_axis_tlast  = out_end_q;

endmodule

@@ hdl/rtmb_port_check.sv @@
`timescale 1ns / 1ps
`include "running_triframe_median_background_unit_assert.svh"

module rtmb_port_check (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [rtmb_pkg::SAMPLE_W-1:0]     m_axis_tdata,
	input logic                              m_axis_tuser
);
	import rtmb_pkg::*;

	logic [3:0] pend_q;
	logic       seen_ready_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_axis_tvalid & s_axis_tready;
	assign out_acc = m_axis_tvalid & m_axis_tready;

	// Track beats in flight and whether the background was reported ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			seen_ready_q <= 1'b0;
		end else begin
			if (in_acc && !out_acc)
				pend_q <= pend_q + 4'd1;
			else if (out_acc && !in_acc)
				pend_q <= pend_q - 4'd1;
			if (out_acc && m_axis_tuser)
				seen_ready_q <= 1'b1;
		end
	end

	`RTMB_ASSERT_IMPL(a_no_orphan_result, m_axis_tvalid, pend_q != 4'd0, "result with no input")
	`RTMB_ASSERT_IMPL(a_ready_only_when_full, !s_axis_tready, pend_q >= 4'd4, "input stalled early")
	`RTMB_ASSERT_IMPL(a_ready_sticks, m_axis_tvalid && seen_ready_q, m_axis_tuser, "ready flag fell")
	`RTMB_ASSERT_HOLD(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "stalled data moved")

endmodule

bind running_triframe_median_background_unit rtmb_port_check u_port_check (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import rtmb_pkg::*;

	typedef struct {
		cmd_t                cmd;
		logic [SAMPLE_W-1:0] sample;
		logic [ADDR_W-1:0]   index;
	} frame_beat_t;

	typedef struct {
		logic [SAMPLE_W-1:0] value;
		logic                bg_ready;
		logic                frame_end;
	} bg_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0]     m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    m_axis_tlast;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [LEN_W-1:0]        cfg_data = '0;

	// Beats waiting to be offered, and results still owed by the unit
	frame_beat_t             frame_beats_todo[$];
	bg_beat_t                bg_beats_due[$];
	frame_beat_t             offered_beat;

	// Mirror of the estimator state
	logic [SAMPLE_W-1:0]     bg_bytes[int];
	logic [SAMPLE_W-1:0]     held_bytes[int];
	int                      byte_pos = 0;
	slot_t                   cur_slot = SLOT_FIRST;
	logic                    first_stored = 1'b0;
	logic [LEN_W-1:0]        frame_len = FRAME_LEN_RESET;
	int                      bg_extent = 0;
	int                      held_extent = 0;

	// Idle control and counters
	int                      src_odds = 0;
	int                      snk_odds = 0;
	int                      src_gap = 0;
	int                      snk_gap = 0;
	int                      hold_left = 0;
	logic                    hold_done = 1'b0;
	int                      beats_in = 0;
	int                      bad_beats = 0;

	running_triframe_median_background_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [SAMPLE_W-1:0] mid_of_three(
		input logic [SAMPLE_W-1:0] a,
		input logic [SAMPLE_W-1:0] b,
		input logic [SAMPLE_W-1:0] c
	);
		logic [SAMPLE_W-1:0] lo_ab;
		logic [SAMPLE_W-1:0] hi_ab;
		lo_ab = (a < b) ? a : b;
		hi_ab = (a < b) ? b : a;
		if (c <= lo_ab)
			return lo_ab;
		if (c >= hi_ab)
			return hi_ab;
		return c;
	endfunction

	// Advance the background mirror by one accepted beat and queue its result
	function automatic void track_background(input frame_beat_t fb);
		bg_beat_t res;
		int span;
		res.frame_end = 1'b0;
		if (fb.cmd == CMD_READ) begin
			res.value = bg_bytes.exists(int'(fb.index)) ? bg_bytes[int'(fb.index)] : '0;
		end else begin
			span = (frame_len == 0) ? 1 :
				(frame_len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(frame_len);
			case (cur_slot)
				SLOT_FIRST: begin
					bg_bytes[byte_pos] = fb.sample;
				end
				SLOT_HOLD: begin
					held_bytes[byte_pos] = fb.sample;
					if (byte_pos + 1 > held_extent)
						held_extent = byte_pos + 1;
				end
				default: begin
					bg_bytes[byte_pos] = mid_of_three(bg_bytes[byte_pos],
						held_bytes[byte_pos], fb.sample);
				end
			endcase
			if (byte_pos + 1 > bg_extent && cur_slot == SLOT_FIRST)
				bg_extent = byte_pos + 1;
			res.value = bg_bytes[byte_pos];
			byte_pos++;
			if (byte_pos >= span) begin
				res.frame_end = 1'b1;
				byte_pos = 0;
				case (cur_slot)
					SLOT_FIRST: begin
						first_stored = 1'b1;
						cur_slot = SLOT_HOLD;
					end
					SLOT_HOLD: cur_slot = SLOT_MERGE;
					default:   cur_slot = SLOT_HOLD;
				endcase
			end
		end
		res.bg_ready = first_stored;
		bg_beats_due.push_back(res);
	endfunction

	// Source side: hold the offered beat until taken, insert idle bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				track_background(offered_beat);
				beats_in <= beats_in + 1;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				s_axis_tvalid <= 1'b1;
			end else if (src_gap != 0) begin
				src_gap = src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
				src_gap = $urandom_range(0, 6);
				s_axis_tvalid <= 1'b0;
			end else if (frame_beats_todo.size() != 0) begin
				offered_beat = frame_beats_todo.pop_front();
				s_axis_tdata <= {4'b0, offered_beat.index, offered_beat.sample};
				s_axis_tuser <= offered_beat.cmd;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Sink side: check each result beat against the oldest expectation
	always @(posedge clk) begin
		bg_beat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (bg_beats_due.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("unexpected result beat: value %02h ready %b last %b",
							m_axis_tdata, m_axis_tuser, m_axis_tlast);
				end else begin
					want = bg_beats_due.pop_front();
					if (m_axis_tdata !== want.value || m_axis_tuser !== want.bg_ready ||
					    m_axis_tlast !== want.frame_end) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display({"result beat differs: expected value %02h ready %b ",
								"last %b, got value %02h ready %b last %b"},
								want.value, want.bg_ready, want.frame_end,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap = snk_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
				snk_gap = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Long receiver stall once, mid-run, so the input queue fills and backs up
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			else if (!hold_done && beats_in >= 150) begin
				hold_left <= 80;
				hold_done <= 1'b1;
			end
		end
	end

	task automatic add_push(input logic [SAMPLE_W-1:0] sample, input logic [ADDR_W-1:0] index);
		frame_beat_t fb;
		fb.cmd = CMD_PUSH;
		fb.sample = sample;
		fb.index = index;
		frame_beats_todo.push_back(fb);
	endtask

	task automatic add_read(input logic [ADDR_W-1:0] index, input logic [SAMPLE_W-1:0] sample);
		frame_beat_t fb;
		fb.cmd = CMD_READ;
		fb.sample = sample;
		fb.index = index;
		frame_beats_todo.push_back(fb);
	endtask

	// Wait until every beat is sent and answered, then let the pipeline settle
	task automatic wait_drained();
		while (frame_beats_todo.size() != 0 || s_axis_tvalid || bg_beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_frame_length(input logic [LEN_W-1:0] len);
		@(posedge clk);
		cfg_data <= len;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		frame_len = len;
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int cap;
		int src_plan[8];
		int snk_plan[8];
		logic [SAMPLE_W-1:0] s;
		logic [LEN_W-1:0] len;

		src_plan = '{4, 0, 3, 8, 2, 5, 6, 0};
		snk_plan = '{3, 5, 0, 2, 8, 4, 6, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// First frame under the reset length: extremes of sample and index
		src_odds = 3;
		snk_odds = 3;
		add_push(8'h00, 20'hFFFFF);
		add_push(8'hFF, 20'h00000);
		add_push(8'hA5, 20'hAAAAA);
		add_push(8'h5A, 20'h55555);
		add_push(8'h01, 20'h00000);
		add_read(20'd0, 8'hFF);
		add_read(20'd3, 8'h00);
		wait_drained();

		// Largest legal length, then the all-ones length far above it: the frame keeps running
		write_frame_length(LEN_W'(MAX_FRAME_BYTES));
		add_push(8'h80, 20'd0);
		add_push(8'h7F, 20'd0);
		add_push(8'h40, 20'd0);
		add_read(20'd6, 8'h00);
		wait_drained();
		write_frame_length({LEN_W{1'b1}});
		add_push(8'h20, 20'd0);
		add_push(8'hC0, 20'd0);
		add_push(8'h10, 20'd0);
		wait_drained();

		// Length zero mid-frame: the next push closes the first frame,
		// then one-byte frames alternate hold and merge at position 0
		write_frame_length('0);
		add_push(8'hEE, 20'd0);
		add_push(8'h80, 20'd0);
		add_push(8'h40, 20'd0);
		add_push(8'h10, 20'd0);
		add_push(8'hFF, 20'd0);
		add_push(8'hC0, 20'd0);
		add_push(8'h50, 20'd0);
		add_read(20'd11, 8'h00);
		wait_drained();
		write_frame_length(LEN_W'(1));

		// Random phases; lengths stay within written store entries
		for (int ph = 0; ph < 8; ph++) begin
			cap = bg_extent;
			if (cur_slot == SLOT_MERGE && held_extent < cap)
				cap = held_extent;
			case ($urandom_range(0, 3))
				0:       len = '0;
				1:       len = LEN_W'(1);
				2:       len = LEN_W'(cap);
				default: len = LEN_W'($urandom_range(1, cap));
			endcase
			if (ph == 0)
				len = LEN_W'(cap);
			write_frame_length(len);
			src_odds = src_plan[ph];
			snk_odds = snk_plan[ph];
			for (int n = 0; n < 80; n++) begin
				case ($urandom_range(0, 7))
					0:       s = 8'h00;
					1:       s = 8'hFF;
					2:       s = 8'($urandom_range(126, 130));
					default: s = 8'($urandom);
				endcase
				if ($urandom_range(0, 4) == 0)
					add_read(ADDR_W'($urandom_range(0, bg_extent - 1)), 8'($urandom));
				else
					add_push(s, ADDR_W'($urandom));
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (bad_beats == 0)
			$display("running_triframe_median_background_unit: match");
		else
			$display("running_triframe_median_background_unit: mismatch");
		$finish;
	end

	// Stop a hung run
	initial begin
		#400000;
		$display("running_triframe_median_background_unit: mismatch");
		$finish;
	end

endmodule
